// ===== rtl/core/rational_arithmetic_unit_top_assert.svh =====
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define RAU_ASSERT_NXT(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/core/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, codes and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
    localparam int RAU_WIDTH = 32;
    localparam int PW = 64;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0, ACT_SUB = 3'd1, ACT_MUL = 3'd2,
        ACT_DIV = 3'd3, ACT_LT = 3'd4, ACT_EQ = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_ZERO = 2'd1, ST_OVF = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_FORM, S_GCD, S_DIVN, S_DIVD, S_CHECK, S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic form;
        logic gcd_step;
        logic div_start_n;
        logic div_start_d;
        logic div_step;
        logic check;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic early;     // result decided at load, or by the products for a compare
        logic gcd_done;
        logic div_done;
    } sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: products, Euclid loop, two divisions, range check, output.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_fire,
    input  wire logic out_fire,
    input  wire sts_t sts,
    output cmd_t      cmd,
    output logic      busy,
    output logic      done
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_MUL1;
            S_MUL1:  state_next = sts.early ? S_OUT : S_MUL2;
            S_MUL2:  state_next = sts.early ? S_OUT : S_FORM;
            S_FORM:  state_next = S_GCD;
            S_GCD:   if (sts.gcd_done) state_next = S_DIVN;
            S_DIVN:  if (sts.div_done) state_next = S_DIVD;
            S_DIVD:  if (sts.div_done) state_next = S_CHECK;
            S_CHECK: state_next = S_OUT;
            S_OUT:   if (out_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:  cmd.load = in_fire;
            S_MUL1:  cmd.mul1 = 1'b1;
            S_MUL2:  cmd.mul2 = 1'b1;
            S_FORM:  cmd.form = 1'b1;
            S_GCD: begin
                cmd.gcd_step = 1'b1;
                cmd.div_start_n = sts.gcd_done;
            end
            S_DIVN: begin
                cmd.div_step = 1'b1;
                cmd.div_start_d = sts.div_done;
            end
            S_DIVD:  cmd.div_step = 1'b1;
            S_CHECK: cmd.check = 1'b1;
            default: cmd = '0;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);
endmodule
`default_nettype wire

// ===== rtl/core/rau_dp.sv =====
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: two 32x32 multipliers, subtractive-free Euclid by restoring division,
// and a shared bit-serial 64-bit divider for the reduction.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_dp
    import rau_pkg::*;
#(
    parameter int WIDTH = RAU_WIDTH
) (
    input  wire logic               aclk,
    input  wire cmd_t               cmd,
    input  wire logic [2:0]         action,
    input  wire logic signed [31:0] lhs_num,
    input  wire logic [30:0]        lhs_den,
    input  wire logic signed [31:0] rhs_num,
    input  wire logic [30:0]        rhs_den,
    output sts_t                    sts,
    output logic signed [31:0]      res_num,
    output logic [30:0]             res_den,
    output logic                    truth,
    output logic [1:0]              status
);
    localparam logic [PW-1:0] LIM = {{(PW-1){1'b0}}, 1'b1} << (WIDTH - 1);

    logic signed [31:0] a_reg, c_reg;
    logic [30:0]        b_reg, d_reg;
    logic [2:0]         act_reg;
    logic               early_reg;
    logic signed [63:0] p1_reg, p2_reg, p3_reg;
    logic               neg_reg;
    logic [PW-1:0]      x_reg, y_reg, mag_reg, dmag_reg;
    // Shared restoring divider.
    logic [PW-1:0]      q_reg, r_reg, dv_reg, dd_reg;
    logic [6:0]         cnt_reg;
    logic               dmode_reg;   // 0: remainder for Euclid, 1: quotient
    logic               drun_reg;

    logic signed [31:0] m1a, m1b, m2a, m2b;
    logic signed [63:0] pn, pd;
    logic [PW-1:0]      r_sh, q_sh;
    logic               ge;

    assign sts.early = early_reg;
    assign sts.gcd_done = !drun_reg && (y_reg == '0);
    assign sts.div_done = !drun_reg && (cnt_reg == '0) && dmode_reg;

    // Product operand selection for the S_MUL1 and S_MUL2 states.
    always_comb begin
        m1a = a_reg;
        m1b = $signed({1'b0, d_reg});
        m2a = c_reg;
        m2b = $signed({1'b0, b_reg});
        if (cmd.mul2) begin
            m1a = $signed({1'b0, b_reg});
            m1b = (act_reg == ACT_DIV) ? c_reg : $signed({1'b0, d_reg});
            m2a = a_reg;
            m2b = c_reg;
        end
    end

    always_comb begin
        pd = p3_reg;
        unique case (act_reg)
            ACT_ADD: pn = p1_reg + p2_reg;
            ACT_SUB: pn = p1_reg - p2_reg;
            ACT_MUL: pn = p2_reg;
            default: pn = p1_reg;
        endcase
    end

    assign r_sh = {r_reg[PW-2:0], dd_reg[PW-1]};
    assign ge   = (r_sh >= dv_reg);
    assign q_sh = {q_reg[PW-2:0], ge};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg <= lhs_num;
            b_reg <= lhs_den;
            c_reg <= rhs_num;
            d_reg <= rhs_den;
            act_reg <= action;
            drun_reg <= 1'b0;
            cnt_reg <= '0;
            dmode_reg <= 1'b0;
            res_num <= '0;
            res_den <= 31'd1;
            truth <= 1'b0;
            if (action > 3'(ACT_EQ)) begin
                early_reg <= 1'b1;
                status <= ST_OK;
            end else if (lhs_den == '0 || rhs_den == '0 ||
                         (action == 3'(ACT_DIV) && rhs_num == '0)) begin
                early_reg <= 1'b1;
                status <= ST_ZERO;
            end else begin
                early_reg <= 1'b0;   // compare and arithmetic need the products
                status <= ST_OK;
            end
        end
        if (cmd.mul1) begin
            p1_reg <= 64'(m1a * m1b);
            p2_reg <= 64'(m2a * m2b);
            // A compare finishes once its truth is taken in the next cycle.
            if (act_reg == ACT_LT || act_reg == ACT_EQ) early_reg <= 1'b1;
        end
        if (cmd.mul2) begin
            if (act_reg == ACT_LT || act_reg == ACT_EQ) begin
                truth <= (act_reg == ACT_LT) ? (p1_reg < p2_reg) : (p1_reg == p2_reg);
            end
            p3_reg <= 64'(m1a * m1b);
            if (act_reg == ACT_MUL) p2_reg <= 64'(m2a * m2b);
        end
        if (cmd.form) begin
            neg_reg <= (pn < 0) != (pd < 0);
            mag_reg <= pn[63] ? 64'(-pn) : 64'(pn);
            dmag_reg <= pd[63] ? 64'(-pd) : 64'(pd);
            x_reg <= pn[63] ? 64'(-pn) : 64'(pn);
            y_reg <= pd[63] ? 64'(-pd) : 64'(pd);
            drun_reg <= 1'b0;
        end
        // Euclid: each iteration runs a full remainder through the divider.
        if (cmd.gcd_step && y_reg != '0 && !drun_reg) begin
            dd_reg <= x_reg;
            dv_reg <= y_reg;
            r_reg <= '0;
            q_reg <= '0;
            cnt_reg <= 7'(PW);
            dmode_reg <= 1'b0;
            drun_reg <= 1'b1;
        end
        if (drun_reg) begin
            r_reg <= ge ? r_sh - dv_reg : r_sh;
            q_reg <= q_sh;
            dd_reg <= {dd_reg[PW-2:0], 1'b0};
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                drun_reg <= 1'b0;
                if (!dmode_reg) begin
                    x_reg <= y_reg;
                    y_reg <= ge ? r_sh - dv_reg : r_sh;
                end
            end
        end
        if (cmd.div_start_n) begin
            dd_reg <= mag_reg;
            dv_reg <= x_reg;
            r_reg <= '0;
            q_reg <= '0;
            cnt_reg <= 7'(PW);
            dmode_reg <= 1'b1;
            drun_reg <= 1'b1;
        end
        if (cmd.div_step && sts.div_done) begin
            mag_reg <= cmd.div_start_d ? q_reg : mag_reg;
            dmag_reg <= cmd.div_start_d ? dmag_reg : q_reg;
        end
        if (cmd.div_start_d) begin
            dd_reg <= dmag_reg;
            dv_reg <= x_reg;
            r_reg <= '0;
            q_reg <= '0;
            cnt_reg <= 7'(PW);
            dmode_reg <= 1'b1;
            drun_reg <= 1'b1;
        end
        if (cmd.check) begin
            if (mag_reg == '0) begin
                res_num <= '0;
                res_den <= 31'd1;
            end else if (dmag_reg > LIM - 64'd1 ||
                         (neg_reg ? (mag_reg > LIM) : (mag_reg > LIM - 64'd1))) begin
                status <= ST_OVF;
            end else begin
                res_num <= neg_reg ? 32'(-mag_reg) : 32'(mag_reg);
                res_den <= 31'(dmag_reg);
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/rational_arithmetic_unit_top.sv =====
// An unused action or an error leaves for the output from S_MUL1, a compare
// leaves after the products, and arithmetic runs the products, up to about 92
// Euclid iterations, the two reductions and the range check.
// One item at a time, taken again only back in idle; the bit-serial 64-bit divider,
// shared by the Euclid loop and the two reductions, sets the throughput. Reset (aresetn
// low, synchronous) returns the sequencer to idle; no state survives items.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Fraction add, subtract, multiply, divide and compare with gcd reduction.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rational_arithmetic_unit_top_assert.svh"
module rational_arithmetic_unit_top
    import rau_pkg::*;
#(
    parameter int WIDTH = RAU_WIDTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_action,
    input  wire logic signed [31:0] s_lhs_num,
    input  wire logic [30:0]        s_lhs_den,
    input  wire logic signed [31:0] s_rhs_num,
    input  wire logic [30:0]        s_rhs_den,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_res_num,
    output logic [30:0]             m_res_den,
    output logic                    m_truth,
    output logic [1:0]              m_status
);
    cmd_t cmd;
    sts_t sts;
    logic busy, done;

    // The input is taken only when the sequencer is idle; the result is held
    // in the datapath's output registers until its transfer completes.
    assign s_ready = !busy;
    assign m_valid = done;

    rau_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_valid && s_ready), .out_fire(m_valid && m_ready),
        .sts(sts), .cmd(cmd), .busy(busy), .done(done)
    );

    rau_dp #(.WIDTH(WIDTH)) u_dp (
        .aclk(aclk), .cmd(cmd),
        .action(s_action), .lhs_num(s_lhs_num), .lhs_den(s_lhs_den),
        .rhs_num(s_rhs_num), .rhs_den(s_rhs_den), .sts(sts),
        .res_num(m_res_num), .res_den(m_res_den),
        .truth(m_truth), .status(m_status)
    );

    // The result denominator is never zero when offered.
    `RAU_ASSERT_IMP(a_den_nonzero, aclk, aresetn, m_valid, m_res_den != '0, "zero denominator")
    // A held result stays put until its transfer completes.
    `RAU_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_res_num),
                    "result changed while stalled")
    // Input is never taken while a result waits.
    `RAU_ASSERT_IMP(a_excl, aclk, aresetn, m_valid, !s_ready, "input taken while busy")
endmodule
`default_nettype wire

// ===== tb/rational_arithmetic_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_checker
// Predicts each fraction result and compares it with the output transfers.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_checker
    import rau_pkg::*;
#(
    parameter int WIDTH = RAU_WIDTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [2:0]         s_action,
    input  wire logic signed [31:0] s_lhs_num,
    input  wire logic [30:0]        s_lhs_den,
    input  wire logic signed [31:0] s_rhs_num,
    input  wire logic [30:0]        s_rhs_den,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic signed [31:0] m_res_num,
    input  wire logic [30:0]        m_res_den,
    input  wire logic               m_truth,
    input  wire logic [1:0]         m_status,
    output int                      fail_count,
    output int                      pending_count
);
    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               truth;
        logic [1:0]         status;
    } fraction_result_t;

    fraction_result_t expected_fractions[$];

    function automatic fraction_result_t plain_result(logic t, logic [1:0] st);
        fraction_result_t r;
        r.num = '0;
        r.den = 31'd1;
        r.truth = t;
        r.status = st;
        return r;
    endfunction

    function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
        longint unsigned r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic fraction_result_t reduce_fraction(logic [2:0] act,
            longint a, longint b, longint c, longint d);
        longint pn;
        longint pd;
        logic neg;
        longint unsigned mag;
        longint unsigned dmag;
        longint unsigned g;
        longint unsigned lim;
        fraction_result_t r;
        lim = 64'd1 << (WIDTH - 1);
        if (act > ACT_EQ) return plain_result(1'b0, ST_OK);
        if (b == 0 || d == 0) return plain_result(1'b0, ST_ZERO);
        if (act == ACT_LT) return plain_result(a * d < c * b, ST_OK);
        if (act == ACT_EQ) return plain_result(a * d == c * b, ST_OK);
        case (act)
            ACT_ADD: begin pn = a * d + c * b; pd = b * d; end
            ACT_SUB: begin pn = a * d - c * b; pd = b * d; end
            ACT_MUL: begin pn = a * c; pd = b * d; end
            default: begin
                if (c == 0) return plain_result(1'b0, ST_ZERO);
                pn = a * d;
                pd = b * c;
            end
        endcase
        neg = (pn < 0) != (pd < 0);
        mag = (pn < 0) ? -pn : pn;
        dmag = (pd < 0) ? -pd : pd;
        g = euclid(mag, dmag);
        mag = mag / g;
        dmag = dmag / g;
        if (mag == 0) begin
            neg = 1'b0;
            dmag = 1;
        end
        if (dmag > lim - 1) return plain_result(1'b0, ST_OVF);
        if (neg ? (mag > lim) : (mag > lim - 1)) return plain_result(1'b0, ST_OVF);
        r.num = 32'(neg ? -mag : mag);
        r.den = dmag[30:0];
        r.truth = 1'b0;
        r.status = ST_OK;
        return r;
    endfunction

    assign pending_count = expected_fractions.size();

    always @(posedge aclk) begin
        fraction_result_t e;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_fractions.push_back(reduce_fraction(s_action, s_lhs_num,
                    s_lhs_den, s_rhs_num, s_rhs_den));
            if (m_valid && m_ready) begin
                if (expected_fractions.size() == 0) begin
                    $error("unexpected result transfer");
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_fractions.pop_front();
                    if (m_res_num !== e.num || m_res_den !== e.den ||
                            m_truth !== e.truth || m_status !== e.status) begin
                        if (m_res_num !== e.num)
                            $error("res_num expected %0d actual %0d", e.num, m_res_num);
                        if (m_res_den !== e.den)
                            $error("res_den expected %0d actual %0d", e.den, m_res_den);
                        if (m_truth !== e.truth)
                            $error("truth expected %0d actual %0d", e.truth, m_truth);
                        if (m_status !== e.status)
                            $error("status expected %0d actual %0d", e.status, m_status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/rational_arithmetic_unit_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top_test
// Directed and random fraction operations with random gaps and stalls.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top_test;
    import rau_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    // No transfer for this long means the block has hung; the limit outlasts
    // the slowest item and the longest receiver stall.
    localparam int HANG_LIMIT = 40000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_action = '0;
    logic signed [31:0] s_lhs_num = '0;
    logic [30:0]        s_lhs_den = '0;
    logic signed [31:0] s_rhs_num = '0;
    logic [30:0]        s_rhs_den = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_res_num;
    logic [30:0]        m_res_den;
    logic               m_truth;
    logic [1:0]         m_status;
    int                 fail_count;
    int                 pending_count;
    int                 quiet_cycles = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    rational_arithmetic_unit_top dut (.*);

    rational_arithmetic_unit_checker checker_i (.*);

    // Mostly short gaps, now and then a long one, and often none at all.
    function automatic int gap_length();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 93) return $urandom_range(3, 1);
        return $urandom_range(200, 20);
    endfunction

    // Operand values biased towards the extremes, small values and zero.
    function automatic logic [31:0] pick_num();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(signed'($urandom_range(20)) - 10);
            3: return 32'(signed'($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_den();
        case ($urandom_range(7))
            0: return 31'h7fff_ffff;
            1: return 31'd1;
            2: return 31'($urandom_range(12, 1));
            3: return 31'($urandom_range(1000, 1));
            default: return 31'($urandom_range(32'h7fff_ffff, 1));
        endcase
    endfunction

    // Offers one item, holds it until the transfer, then waits out a gap.
    task automatic send_fraction(logic [2:0] act, logic [31:0] ln, logic [30:0] ld,
                                 logic [31:0] rn, logic [30:0] rd);
        int gap;
        s_valid   <= 1'b1;
        s_action  <= act;
        s_lhs_num <= ln;
        s_lhs_den <= ld;
        s_rhs_num <= rn;
        s_rhs_den <= rd;
        do @(posedge aclk); while (!s_ready);
        gap = gap_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // The receiver stalls at random; early on it holds off for a long stretch
    // so that the block fills up while the sender keeps offering.
    initial begin
        int stall;
        repeat (10) @(posedge aclk);
        m_ready <= 1'b0;
        repeat (1500) @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(30, 1)) @(posedge aclk);
            stall = gap_length();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Watchdog on transfers of either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [2:0] act;
        logic [31:0] ln;
        logic [31:0] rn;
        logic [30:0] ld;
        logic [30:0] rd;
        int p;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: every action, the field extremes, the zero
        // denominator, division by a zero fraction, overflow, zero results
        // and the two unused action codes.
        send_fraction(ACT_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3);
        send_fraction(ACT_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2);
        send_fraction(ACT_MUL, -32'sd3, 31'd4, 32'sd2, 31'd9);
        send_fraction(ACT_DIV, 32'sd5, 31'd7, -32'sd10, 31'd21);
        send_fraction(ACT_LT, -32'sd1, 31'd3, 32'sd1, 31'd3);
        send_fraction(ACT_LT, 32'sd1, 31'd3, 32'sd1, 31'd3);
        send_fraction(ACT_EQ, 32'sd2, 31'd4, 32'sd1, 31'd2);
        send_fraction(ACT_EQ, 32'sd2, 31'd4, 32'sd1, 31'd3);
        send_fraction(ACT_ADD, 32'sd1, 31'd0, 32'sd1, 31'd1);
        send_fraction(ACT_LT, 32'sd1, 31'd1, 32'sd1, 31'd0);
        send_fraction(ACT_DIV, 32'sd1, 31'd2, 32'sd0, 31'd5);
        send_fraction(ACT_MUL, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1);
        send_fraction(ACT_MUL, 32'h8000_0000, 31'd1, 32'sd1, 31'd1);
        send_fraction(ACT_MUL, 32'h8000_0000, 31'd1, -32'sd1, 31'd1);
        send_fraction(ACT_SUB, 32'h8000_0000, 31'd1, 32'h7fff_ffff, 31'd1);
        send_fraction(ACT_ADD, 32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000,
                      31'h7fff_fffe);
        send_fraction(ACT_DIV, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000,
                      31'h7fff_ffff);
        send_fraction(ACT_MUL, 32'sd0, 31'd5, -32'sd7, 31'd3);
        send_fraction(ACT_LT, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 31'd1);
        send_fraction(ACT_EQ, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000,
                      31'h7fff_ffff);
        send_fraction(3'd6, 32'sd1, 31'd1, 32'sd1, 31'd1);
        send_fraction(3'd7, -32'sd1, 31'd0, 32'sd0, 31'd0);

        // Random part: mostly valid actions, a few zero denominators
        // and unused codes.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            p = $urandom_range(99);
            act = (p < 3) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
            ln = pick_num();
            rn = pick_num();
            ld = ($urandom_range(39) == 0) ? 31'd0 : pick_den();
            rd = ($urandom_range(39) == 0) ? 31'd0 : pick_den();
            send_fraction(act, ln, ld, rn, rd);
        end
        s_valid <= 1'b0;

        // One edge first so that the last transfer is already counted, then
        // drain and let the block settle before the verdict.
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
